FILE: src/slip_frame_receiver_assert.svh
// Assertion macros used by the checker module of the SLIP frame receiver.
// Depends on nothing; included by the checker file only.
`ifndef SLIP_FRAME_RECEIVER_ASSERT_SVH
`define SLIP_FRAME_RECEIVER_ASSERT_SVH

// Asserts a property on the rising clock edge, disabled while reset is low.
`define SLIPFR_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("%m: assertion failed");

// Asserts that a condition never holds on the rising clock edge outside reset.
`define SLIPFR_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

FILE: src/slipfr_pkg.sv
// Package of the SLIP frame receiver: framing codes, result kinds and sizes.
// Depends on nothing; used by the result interface, the top level and the checker.
`default_nettype none

package slipfr_pkg;

  localparam int unsigned MaxRawLen = 256;
  localparam int unsigned CountW    = $clog2(MaxRawLen + 1);

  localparam logic [7:0] SlipEnd    = 8'hC0;
  localparam logic [7:0] SlipEsc    = 8'hDB;
  localparam logic [7:0] SlipEscEnd = 8'hDC;
  localparam logic [7:0] SlipEscEsc = 8'hDD;

  typedef enum logic [1:0] {
    KindData  = 2'd0,
    KindEnd   = 2'd1,
    KindAbort = 2'd2
  } kind_e;

endpackage

`default_nettype wire

FILE: src/slipfr_if.sv
// Handshake interfaces of the SLIP frame receiver: raw byte input and result output.
// Depends on slipfr_pkg for the result kind type.
`default_nettype none

interface slipfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface slipfr_out_if
  import slipfr_pkg::*;
;
  logic       valid;
  logic       ready;
  kind_e      kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink (input valid, input kind, input data_byte, output ready);
endinterface

`default_nettype wire

FILE: src/slip_frame_receiver.sv
// SLIP frame receiver top level: decodes one raw serial byte per request.
// Depends on slipfr_pkg and the interfaces in slipfr_if.sv.
//
//   Channel   Dir   Payload               Request
//   rx_i      in    rx_byte[7:0]          one raw byte from the line
//   frame_o   out   kind[1:0], data[7:0]  decoded byte, end or abort marker
//
// One request is accepted per cycle while the result register is empty or being taken.
// A result appears in the cycle after its request; a byte that yields nothing leaves none.
// The single result register sets the rate: a stalled result blocks only new requests.
// Reset clears the framing state and the result valid flag.
`default_nettype none

module slip_frame_receiver
  import slipfr_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  slipfr_in_if.sink    rx_i,
  slipfr_out_if.source frame_o
);

  logic              in_packet_q, in_packet_d;
  logic              esc_q, esc_d;
  logic [CountW-1:0] count_q, count_d;
  logic              out_valid_q, out_valid_d;
  kind_e             kind_q;
  logic [7:0]        data_q;

  logic       in_ready;
  logic       accept;
  logic       res_valid;
  kind_e      res_kind;
  logic [7:0] res_data;
  logic       esc_cur;
  logic [7:0] b;

  localparam logic [CountW-1:0] MaxCount = CountW'(MaxRawLen);

  assign in_ready = !out_valid_q || frame_o.ready;
  assign accept   = rx_i.valid && in_ready;
  assign b        = rx_i.rx_byte;

  always_comb begin
    in_packet_d = in_packet_q;
    esc_d       = esc_q;
    count_d     = count_q;
    res_valid   = 1'b0;
    res_kind    = KindData;
    res_data    = 8'h00;
    esc_cur     = 1'b0;
    if (accept) begin
      if (!in_packet_q) begin
        if (b != SlipEnd) begin
          in_packet_d = 1'b1;
          count_d     = CountW'(1);
          esc_cur     = 1'b0;
        end
      end else if (count_q >= MaxCount) begin
        in_packet_d = 1'b0;
        esc_d       = 1'b0;
        count_d     = '0;
        res_valid   = 1'b1;
        res_kind    = KindAbort;
      end else if (b == SlipEnd) begin
        in_packet_d = 1'b0;
        esc_d       = 1'b0;
        count_d     = '0;
        res_valid   = 1'b1;
        res_kind    = KindEnd;
      end else begin
        count_d = CountW'(count_q + 1'b1);
        esc_cur = esc_q;
      end
      if (in_packet_d && (in_packet_q ? (count_d != count_q) : 1'b1)) begin
        if (esc_cur) begin
          esc_d = 1'b0;
          if (b == SlipEscEnd) begin
            res_valid = 1'b1;
            res_data  = SlipEnd;
          end else if (b == SlipEscEsc) begin
            res_valid = 1'b1;
            res_data  = SlipEsc;
          end
        end else if (b == SlipEsc) begin
          esc_d = 1'b1;
        end else begin
          esc_d     = 1'b0;
          res_valid = 1'b1;
          res_data  = b;
        end
      end
    end
  end

  assign out_valid_d = in_ready ? (accept && res_valid) : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_packet_q <= 1'b0;
      esc_q       <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      in_packet_q <= in_packet_d;
      esc_q       <= esc_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      kind_q <= res_kind;
      data_q <= res_data;
    end
  end

  assign rx_i.ready        = in_ready;
  assign frame_o.valid     = out_valid_q;
  assign frame_o.kind      = kind_q;
  assign frame_o.data_byte = data_q;

endmodule

`default_nettype wire

FILE: src/slipfr_checker.sv
// Port-level checker of the SLIP frame receiver, attached to the top level by bind.
// Depends on slipfr_pkg and the macros in slip_frame_receiver_assert.svh.
`default_nettype none

`include "slip_frame_receiver_assert.svh"

module slipfr_checker
  import slipfr_pkg::*;
(
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_ready_i,
  input wire  [7:0] rx_byte_i,
  input wire        out_valid_i,
  input wire        out_ready_i,
  input wire  [1:0] kind_i,
  input wire  [7:0] data_byte_i
);

  logic in_acc;
  logic out_stall;

  assign in_acc    = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;

  `SLIPFR_ASSERT(a_stall_holds, clk_i, rst_ni,
    out_stall |=> out_valid_i && $stable(kind_i) && $stable(data_byte_i))
  `SLIPFR_ASSERT_NEVER(a_stall_blocks_input, clk_i, rst_ni, out_stall && in_ready_i)
  `SLIPFR_ASSERT_NEVER(a_kind_legal, clk_i, rst_ni,
    out_valid_i && kind_i != KindData && kind_i != KindEnd && kind_i != KindAbort)
  `SLIPFR_ASSERT_NEVER(a_marker_data_zero, clk_i, rst_ni,
    out_valid_i && kind_i != KindData && data_byte_i != 8'h00)
  `SLIPFR_ASSERT(a_end_byte_no_data, clk_i, rst_ni,
    in_acc && rx_byte_i == SlipEnd |=> !out_valid_i || kind_i != KindData)

endmodule

bind slip_frame_receiver slipfr_checker u_slipfr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (rx_i.valid),
  .in_ready_i (rx_i.ready),
  .rx_byte_i  (rx_i.rx_byte),
  .out_valid_i(frame_o.valid),
  .out_ready_i(frame_o.ready),
  .kind_i     (frame_o.kind),
  .data_byte_i(frame_o.data_byte)
);

`default_nettype wire
